>>> src/pdtm_pkg.sv
// Shared constants, types and the sine table generator for the tone mixer.
// Used by the channel interfaces, the divider, the term pipeline and the top level.
// Has no dependencies of its own.
package pdtm_pkg;

    localparam int VOICES       = 16;
    localparam int SINE_ENTRIES = 1024;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SIDX_W = $clog2(SINE_ENTRIES);

    localparam int FREQ_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int LEN_W      = 16;
    localparam int RATE_W     = 18;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = SAMPLE_W - 1;
    localparam int STATUS_W   = 2;
    localparam int PHASE_W    = 32;
    localparam int RECIP_W    = 24;
    localparam int LIN_W      = 17;
    localparam int TERM_W     = 17;
    localparam int MIX_W      = TERM_W + $clog2(VOICES) + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam int DIVIDEND_W = FREQ_W + PHASE_W;
    localparam int DIVISOR_W  = RATE_W;
    localparam int QUOT_W     = 32;

    localparam int CLAMP_LIMIT = 31129;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
    localparam logic [DIVIDEND_W-1:0] RECIP_NUM = DIVIDEND_W'(1) << RECIP_W;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_QUEUE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = CFG_IDX_W'(1);

    localparam logic [STATUS_W-1:0] ST_TICK     = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_DROPPED  = STATUS_W'(2);

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] step;
        logic [GAIN_W-1:0]  gain;
        logic [LEN_W-1:0]   len;
        logic [RECIP_W-1:0] recip;
        logic [LEN_W-1:0]   elapsed;
    } t_voice;

    // One voice's contribution request into the term pipeline.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [SIDX_W-1:0]  idx;
        logic [LEN_W-1:0]   rem;
        logic [RECIP_W-1:0] recip;
        logic [GAIN_W-1:0]  gain;
    } t_term_req;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [TERM_W-1:0] term;
    } t_term_rsp;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [63:0] taylor_next(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Sine table entry, evaluated only on constant indexes at elaboration.
    function automatic logic signed [SAMPLE_W-1:0] rom_entry(input int unsigned k);
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        logic signed [63:0] sum;
        logic [1:0] quad;
        t = (64'(k) << 32) / SINE_ENTRIES;
        quad = t[31:30];
        r = {34'd0, t[29:0]};
        if (quad[0]) begin
            r = ONE_Q30 - r;
        end
        x = (r * HALF_PI_Q30) >> 30;
        sum = $signed(x);
        term = taylor_next(x, x) / 64'd6;
        sum = sum - $signed(term);
        term = taylor_next(term, x) / 64'd20;
        sum = sum + $signed(term);
        term = taylor_next(term, x) / 64'd42;
        sum = sum - $signed(term);
        term = taylor_next(term, x) / 64'd72;
        sum = sum + $signed(term);
        term = taylor_next(term, x) / 64'd110;
        sum = sum - $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = ($unsigned(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return quad[1] ? -$signed(SAMPLE_W'(v)) : $signed(SAMPLE_W'(v));
    endfunction

endpackage

>>> src/pdtm_ifs.sv
// Valid/ready channel interfaces of the tone mixer: tone input, mix output
// and configuration writes. Depends on pdtm_pkg for field widths.
interface pdtm_in_if;
    import pdtm_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [FREQ_W-1:0] tone_freq_hz;
    logic [GAIN_W-1:0] tone_amplitude;
    logic [LEN_W-1:0]  tone_length;

    modport source (output valid, op, tone_freq_hz, tone_amplitude, tone_length,
                    input ready);
    modport sink   (input valid, op, tone_freq_hz, tone_amplitude, tone_length,
                    output ready);
endinterface

interface pdtm_out_if;
    import pdtm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [STATUS_W-1:0]        queue_status;

    modport source (output valid, sample, queue_status, input ready);
    modport sink   (input valid, sample, queue_status, output ready);
endinterface

interface pdtm_cfg_if;
    import pdtm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pdtm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pdtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/pdtm_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on pdtm_pkg for operand widths.
module pdtm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pdtm_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [pdtm_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [pdtm_pkg::QUOT_W-1:0]      o_quotient
);
    import pdtm_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_run;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_dsr;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [QUOT_W-1:0]     r_quo;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W+1:0]  w_diff;
    logic                  w_ge;

    always_comb begin
        w_shift = {r_rem, r_dvd[DIVIDEND_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dsr};
        w_ge    = !w_diff[DIVISOR_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_dvd <= i_dividend;
                r_dsr <= i_divisor;
                r_rem <= '0;
                r_quo <= '0;
            end else if (r_run) begin
                r_dvd <= r_dvd << 1;
                r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
                // Bits above the quotient width fall off the top, which is the wrap we want.
                r_quo <= {r_quo[QUOT_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

>>> src/pdtm_term_pipe.sv
// Three-stage pipeline that turns one voice's phase index and envelope inputs
// into its signed contribution to the mix. Depends on pdtm_pkg (types, sine table).
module pdtm_term_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdtm_pkg::t_term_req   i_req,
    output pdtm_pkg::t_term_rsp   o_rsp
);
    import pdtm_pkg::*;

    logic signed [SAMPLE_W-1:0] w_rom [SINE_ENTRIES];

    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
        assign w_rom[k] = rom_entry(k);
    end

    // Stage 1: table lookup and linear envelope.
    logic                       r_p1_valid;
    logic                       r_p1_last;
    logic signed [SAMPLE_W-1:0] r_sine;
    logic [LIN_W-1:0]           r_lin;
    logic [GAIN_W-1:0]          r_gain;

    // Stage 2: magnitude times gain, and the squared envelope.
    logic                       r_p2_valid;
    logic                       r_p2_last;
    logic                       r_neg;
    logic [MAG_W+GAIN_W-1:0]    r_mg;
    logic [LIN_W-1:0]           r_env;

    t_term_rsp                  r_rsp;

    logic [LEN_W+RECIP_W-1:0]      w_lin_prod;
    logic [MAG_W-1:0]              w_mag;
    logic [2*LIN_W-1:0]            w_env_prod;
    logic [MAG_W+GAIN_W+LIN_W-1:0] w_p_prod;
    logic [TERM_W-1:0]             w_p;

    always_comb begin
        w_lin_prod = LEN_W'(i_req.rem) * i_req.recip;
        w_mag      = r_sine[SAMPLE_W-1] ? MAG_W'(-r_sine) : MAG_W'(r_sine);
        w_env_prod = r_lin * r_lin;
        w_p_prod   = r_mg * r_env;
        w_p        = {1'b0, w_p_prod[32 +: TERM_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p1_last   <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p2_last   <= 1'b0;
            r_rsp.valid <= 1'b0;
            r_rsp.last  <= 1'b0;
        end else begin
            r_p1_valid  <= i_req.valid;
            r_p1_last   <= i_req.last;
            r_p2_valid  <= r_p1_valid;
            r_p2_last   <= r_p1_last;
            r_rsp.valid <= r_p2_valid;
            r_rsp.last  <= r_p2_last;
        end
        r_sine    <= w_rom[i_req.idx];
        r_lin     <= w_lin_prod[8 +: LIN_W];
        r_gain    <= i_req.gain;
        r_neg     <= r_sine[SAMPLE_W-1];
        r_mg      <= w_mag * r_gain;
        r_env     <= w_env_prod[16 +: LIN_W];
        r_rsp.term <= r_neg ? -$signed(w_p) : $signed(w_p);
    end

    assign o_rsp = r_rsp;
endmodule

>>> src/polyphonic_decay_tone_mixer.sv
// Top level of the polyphonic tone mixer: control, voice table, mix and clamp.
// Depends on pdtm_pkg, pdtm_ifs, pdtm_ram, pdtm_div and pdtm_term_pipe.
//
// Usage: items arrive on i_tone. A queue item (op 1) claims the lowest free
// voice; a tick item (op 0) mixes one output sample from all busy voices.
// Every item yields exactly one transaction on o_mix: queue items give
// sample 0 with status accepted or dropped, ticks give the clamped Q1.15 mix.
// i_cfg writes enabled (index 0) and sample_rate (index 1); it is always ready.
//
// Voice records live in one RAM with a registered read. A tick walks all
// VOICES entries one per cycle (read, update, write back) and feeds a
// three-stage term pipeline. A queue item runs through the bit-serial
// dividers that form the phase step and the length reciprocal. Silent
// ticks, zero-length tones and a full table go straight to the result,
// skipping both the voice walk and the dividers.
// One item is in work at a time; i_tone.ready is high whenever the block is
// between items, even while a result still waits in the output register.
// Reset frees all voices and restores enabled 1 and sample_rate 48000.
// When o_mix stalls, the finished result waits until the register empties.
module polyphonic_decay_tone_mixer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdtm_in_if.sink    i_tone,
    pdtm_cfg_if.sink   i_cfg,
    pdtm_out_if.source o_mix
);
    import pdtm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_TICK,
        S_DRAIN,
        S_DONE
    } t_state;

    localparam logic [VIDX_W-1:0]     LAST_VOICE = VIDX_W'(VOICES - 1);
    localparam logic signed [MIX_W-1:0] MIX_HI = MIX_W'(CLAMP_LIMIT);
    localparam logic signed [MIX_W-1:0] MIX_LO = -MIX_HI;

    t_state                     r_state;
    logic                       r_enabled;
    logic [RATE_W-1:0]          r_rate;
    logic [VOICES-1:0]          r_busy;
    logic [VIDX_W-1:0]          r_vidx;

    logic                       r_s1_go;
    logic                       r_s1_busy;
    logic                       r_s1_last;
    logic [VIDX_W-1:0]          r_s1_vidx;
    t_term_req                  r_req;
    logic signed [MIX_W-1:0]    r_mix;

    logic [VIDX_W-1:0]          r_q_voice;
    logic [GAIN_W-1:0]          r_q_gain;
    logic [LEN_W-1:0]           r_q_len;
    logic                       r_q_rate_zero;

    logic signed [SAMPLE_W-1:0] r_res_sample;
    logic [STATUS_W-1:0]        r_res_status;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [STATUS_W-1:0]        r_out_status;

    logic                       w_in_fire;
    logic                       w_free_found;
    logic [VIDX_W-1:0]          w_free_idx;
    logic                       w_div_start;
    logic                       w_div_done;
    logic                       w_recip_done;
    logic [QUOT_W-1:0]          w_step_q;
    logic [QUOT_W-1:0]          w_recip_q;
    logic [RECIP_W-1:0]         w_recip;

    logic [$bits(t_voice)-1:0]  w_ram_rdata;
    t_voice                     w_rd;
    t_voice                     w_wr;
    logic                       w_ram_we;
    logic [VIDX_W-1:0]          w_ram_waddr;

    logic                       w_s1_active;
    logic                       w_s1_live;
    logic                       w_s1_retire;
    logic [PHASE_W-1:0]         w_s1_phase;
    logic [LEN_W-1:0]           w_s1_elapsed;

    t_term_rsp                  w_term;
    logic signed [MIX_W-1:0]    w_mix_final;
    logic signed [MIX_W-1:0]    w_mix_clamped;

    assign w_in_fire   = i_tone.valid && i_tone.ready;
    assign i_tone.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!r_busy[v]) begin
                w_free_found = 1'b1;
                w_free_idx   = VIDX_W'(v);
            end
        end
    end

    assign w_div_start = w_in_fire && (i_tone.op == OP_QUEUE) &&
                         (i_tone.tone_length != '0) && w_free_found;

    pdtm_div u_step_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({i_tone.tone_freq_hz, PHASE_W'(0)}),
        .i_divisor  (r_rate),
        .o_done     (w_div_done),
        .o_quotient (w_step_q)
    );

    pdtm_div u_recip_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (RECIP_NUM),
        .i_divisor  (DIVISOR_W'(i_tone.tone_length)),
        .o_done     (w_recip_done),
        .o_quotient (w_recip_q)
    );

    // A one-sample tone gives a reciprocal of exactly 2^24, which saturates.
    assign w_recip = (w_recip_q[QUOT_W-1:RECIP_W] != '0) ? {RECIP_W{1'b1}}
                                                           : w_recip_q[RECIP_W-1:0];

    pdtm_ram #(
        .WIDTH ($bits(t_voice)),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_wr),
        .i_re    (r_state == S_TICK),
        .i_raddr (r_vidx),
        .o_rdata (w_ram_rdata)
    );

    // RAM read-modify-write of this cycle's entry, or a new voice when dividers finish.
    always_comb begin
        w_rd         = t_voice'(w_ram_rdata);
        w_s1_active  = r_s1_go && r_s1_busy;
        w_s1_live    = w_s1_active && (w_rd.elapsed < w_rd.len);
        w_s1_phase   = w_rd.phase + w_rd.step;
        w_s1_elapsed = w_rd.elapsed + 1'b1;
        w_s1_retire  = w_s1_active && (!w_s1_live || (w_s1_elapsed == w_rd.len));

        if ((r_state == S_DIV) && w_div_done) begin
            w_ram_we      = 1'b1;
            w_ram_waddr   = r_q_voice;
            w_wr.phase    = '0;
            w_wr.step     = r_q_rate_zero ? '0 : w_step_q;
            w_wr.gain     = r_q_gain;
            w_wr.len      = r_q_len;
            w_wr.recip    = w_recip;
            w_wr.elapsed  = '0;
        end else begin
            w_ram_we      = w_s1_live;
            w_ram_waddr   = r_s1_vidx;
            w_wr.phase    = w_s1_phase;
            w_wr.step     = w_rd.step;
            w_wr.gain     = w_rd.gain;
            w_wr.len      = w_rd.len;
            w_wr.recip    = w_rd.recip;
            w_wr.elapsed  = w_s1_elapsed;
        end
    end

    pdtm_term_pipe u_term_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_term)
    );

    always_comb begin
        w_mix_final = r_mix + (w_term.valid ? MIX_W'(w_term.term) : MIX_W'(0));
        if (w_mix_final > MIX_HI) begin
            w_mix_clamped = MIX_HI;
        end else if (w_mix_final < MIX_LO) begin
            w_mix_clamped = MIX_LO;
        end else begin
            w_mix_clamped = w_mix_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b1;
            r_rate      <= RATE_RESET;
            r_busy      <= '0;
            r_vidx      <= '0;
            r_s1_go     <= 1'b0;
            r_s1_last   <= 1'b0;
            r_req.valid <= 1'b0;
            r_req.last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ENABLED:     r_enabled <= i_cfg.data[0];
                    CFG_SAMPLE_RATE: r_rate    <= RATE_W'(i_cfg.data);
                    default:         ;
                endcase
            end

            if (o_mix.ready) begin
                r_out_valid <= 1'b0;
            end

            r_s1_go     <= 1'b0;
            r_req.valid <= w_s1_live;
            r_req.last  <= r_s1_go && r_s1_last;
            r_req.idx   <= w_s1_phase[PHASE_W-1 -: SIDX_W];
            r_req.rem   <= w_rd.len - w_rd.elapsed;
            r_req.recip <= w_rd.recip;
            r_req.gain  <= w_rd.gain;

            if (w_s1_retire) begin
                r_busy[r_s1_vidx] <= 1'b0;
            end
            if (w_term.valid) begin
                r_mix <= w_mix_final;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_res_sample <= '0;
                        if (i_tone.op == OP_QUEUE) begin
                            if (i_tone.tone_length == '0) begin
                                r_res_status <= ST_ACCEPTED;
                                r_state      <= S_DONE;
                            end else if (!w_free_found) begin
                                r_res_status <= ST_DROPPED;
                                r_state      <= S_DONE;
                            end else begin
                                r_q_voice     <= w_free_idx;
                                r_q_gain      <= i_tone.tone_amplitude;
                                r_q_len       <= i_tone.tone_length;
                                r_q_rate_zero <= (r_rate == '0);
                                r_state       <= S_DIV;
                            end
                        end else if (!r_enabled || (r_rate == '0)) begin
                            r_res_status <= ST_TICK;
                            r_state      <= S_DONE;
                        end else begin
                            r_vidx  <= '0;
                            r_mix   <= '0;
                            r_state <= S_TICK;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_busy[r_q_voice] <= 1'b1;
                        r_res_status      <= ST_ACCEPTED;
                        r_state           <= S_DONE;
                    end
                end
                S_TICK: begin
                    r_s1_go   <= 1'b1;
                    r_s1_busy <= r_busy[r_vidx];
                    r_s1_vidx <= r_vidx;
                    r_s1_last <= (r_vidx == LAST_VOICE);
                    r_vidx    <= r_vidx + 1'b1;
                    if (r_vidx == LAST_VOICE) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // The last voice's tag trails every earlier term through the pipeline.
                    if (w_term.last) begin
                        r_res_sample <= SAMPLE_W'(w_mix_clamped);
                        r_res_status <= ST_TICK;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_mix.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_res_sample;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_mix.valid        = r_out_valid;
    assign o_mix.sample       = r_out_sample;
    assign o_mix.queue_status = r_out_status;

    a_claim_free_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && w_div_done) |-> !r_busy[r_q_voice])
        else $error("queue completion claims a voice that is already busy");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_go && !r_req.valid && !w_term.valid))
        else $error("voice pipeline still holds work while idle");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_ram_we)
        else $error("voice RAM written while idle");

    a_tick_only_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TICK) || (r_state == S_DRAIN)) |=>
        ($countones(r_busy) <= $past($countones(r_busy))))
        else $error("voice claimed during a tick");

    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> w_recip_done)
        else $error("divider instances out of step");
endmodule
